>>> design/assert_macros.svh
// Assertion macros shared by the timer bank checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define CPTB_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("timer bank check failed");

// Next-cycle implication under reset.
`define CPTB_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("timer bank check failed");

`endif

>>> design/cptb_pkg.sv
// Package: sizes, command codes, control fields and cell control struct for the timer bank.
`default_nettype none
package cptb_pkg;

	localparam int NUM_TIMERS  = 4;
	localparam int COUNT_WIDTH = 16;
	localparam int IRQ_BITS    = 4;
	localparam int RELOAD_W    = 16;
	localparam int RES_W       = 10;

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// prescaler select codes
	localparam logic [1:0] PSC_DIV1    = 2'd0;
	localparam logic [1:0] PSC_DIV64   = 2'd1;
	localparam logic [1:0] PSC_DIV256  = 2'd2;
	localparam logic [1:0] PSC_DIV1024 = 2'd3;

	// byte lanes of the write mask
	localparam int BM_RELOAD_LO = 0;
	localparam int BM_RELOAD_HI = 1;
	localparam int BM_CTRL_LO   = 2;

	// control low byte bit positions
	localparam int CTRL_CASCADE = 2;
	localparam int CTRL_IRQ_EN  = 6;
	localparam int CTRL_START   = 7;

	typedef struct packed {
		logic       tick;
		logic       wr;
		logic [3:0] byte_mask;
	} cell_ctl_t;

	// prescaler divisor, one bit wider than the residue
	function automatic logic [RES_W:0] divisor_of(input logic [1:0] sel);
		logic [RES_W:0] d;
		case (sel)
			PSC_DIV1:    d = (RES_W+1)'(1);
			PSC_DIV64:   d = (RES_W+1)'(64);
			PSC_DIV256:  d = (RES_W+1)'(256);
			PSC_DIV1024: d = (RES_W+1)'(1024);
			default:     d = (RES_W+1)'(1);
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

>>> design/cascadable_prescaled_timer_bank_core.sv
// Top level of the cascadable prescaled timer bank: cell row, command decode, output register.
// A bank of NUM_TIMERS up-counters, one cell each, in a row. Every input transaction is a clock
// tick, a byte-masked register write or a counter read, and produces exactly one result
// transaction carrying read_data (counter on a read, else zero) and irq_pulse (timers that
// overflowed with IRQ enabled on that tick). The bank takes one transaction per clock cycle:
// while in_stall is low; the overflow carry of a tick ripples through all cells of the row
// within the same cycle, so a cascaded chain adds no latency. Each result shows up in the
// cycle after acceptance, from a single output register; in_stall is raised only while it
// is full and downstream stalls it, so input and output run back to back with no bubbles.
`default_nettype none
module cascadable_prescaled_timer_bank_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [1:0]  timer_sel,
	input  wire logic [3:0]  byte_mask,
	input  wire logic [31:0] write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      read_data,
	output logic [3:0]       irq_pulse
);
	import cptb_pkg::*;

	logic                   accept;
	logic                   is_tick;
	logic                   is_write;
	logic                   is_read;

	cell_ctl_t              ctl [NUM_TIMERS];
	logic [NUM_TIMERS:0]    carry;
	logic [NUM_TIMERS-1:0]  irq_cell;
	logic [COUNT_WIDTH-1:0] count [NUM_TIMERS];

	logic [15:0]            rd_mux;
	logic [3:0]             irq_vec;

	logic                   out_valid_q;
	logic [15:0]            read_q;
	logic [3:0]             irq_q;

	// a new transaction enters whenever the output register is free or draining
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		is_tick  = 1'b0;
		is_write = 1'b0;
		is_read  = 1'b0;
		case (cmd)
			CMD_TICK:  is_tick  = accept;
			CMD_WRITE: is_write = accept;
			CMD_READ:  is_read  = accept;
			default:   ; // unused code: no change, all-zero result
		endcase
	end

	// timer 0 has nothing below it, so its carry input is tied off
	assign carry[0] = 1'b0;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		// selects past the row never match, so such writes are dropped
		always_comb begin
			ctl[i].tick      = is_tick;
			ctl[i].wr        = is_write && (32'(timer_sel) == i);
			ctl[i].byte_mask = byte_mask;
		end

		cptb_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[i]),
			.data       (write_data),
			.chain_head (i == 0),
			.carry_in   (carry[i]),
			.carry_out  (carry[i+1]),
			.irq        (irq_cell[i]),
			.count      (count[i])
		);
	end

	// read select: one compare per cell, OR of the matches
	always_comb begin
		rd_mux = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (32'(timer_sel) == i) begin
				rd_mux = rd_mux | 16'(count[i]);
			end
		end
	end

	// only the low four timers have an IRQ bit in the result
	always_comb begin
		irq_vec = '0;
		for (int i = 0; i < IRQ_BITS; i++) begin
			if (i < NUM_TIMERS) begin
				irq_vec[i] = irq_cell[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_q <= is_read ? rd_mux : '0;
			irq_q  <= is_tick ? irq_vec : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_q;
	assign irq_pulse = irq_q;

endmodule
`default_nettype wire

>>> design/cptb_cell.sv
// One timer cell: counter, reload, prescaler and control bits, carry in from the cell below.
`default_nettype none
module cptb_cell (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire cptb_pkg::cell_ctl_t                 ctl,
	input  wire logic [31:0]                         data,
	input  wire logic                                chain_head,
	input  wire logic                                carry_in,
	output logic                                     carry_out,
	output logic                                     irq,
	output logic [cptb_pkg::COUNT_WIDTH-1:0]         count
);
	import cptb_pkg::*;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [RELOAD_W-1:0]    reload_q;
	logic [RELOAD_W-1:0]    reload_nx;
	logic [RES_W-1:0]       residue_q;
	logic [1:0]             psc_q;
	logic                   cascade_q;
	logic                   irq_en_q;
	logic                   run_q;

	logic [7:0]             ctrl;
	logic [RES_W:0]         res_inc;
	logic                   roll;
	logic                   use_carry;
	logic                   inc;
	logic                   ovf;
	logic [COUNT_WIDTH-1:0] reload_ext;
	logic [COUNT_WIDTH-1:0] reload_nx_ext;

	assign ctrl      = data[23:16];
	assign res_inc   = {1'b0, residue_q} + (RES_W+1)'(1);
	assign roll      = res_inc >= divisor_of(psc_q);
	assign use_carry = cascade_q && !chain_head;
	assign inc       = ctl.tick && run_q && (use_carry ? carry_in : roll);
	assign ovf       = inc && (count_q == {COUNT_WIDTH{1'b1}});
	assign carry_out = ovf;
	assign irq       = ovf && irq_en_q;
	assign count     = count_q;

	assign reload_ext    = COUNT_WIDTH'(reload_q);
	assign reload_nx_ext = COUNT_WIDTH'(reload_nx);

	// reload bytes land before the control byte of the same write
	always_comb begin
		reload_nx = reload_q;
		if (ctl.wr && ctl.byte_mask[BM_RELOAD_LO]) begin
			reload_nx[7:0] = data[7:0];
		end
		if (ctl.wr && ctl.byte_mask[BM_RELOAD_HI]) begin
			reload_nx[15:8] = data[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			reload_q  <= '0;
			residue_q <= '0;
			psc_q     <= PSC_DIV1;
			cascade_q <= 1'b0;
			irq_en_q  <= 1'b0;
			run_q     <= 1'b0;
		end else begin
			reload_q <= reload_nx;
			if (ctl.wr && ctl.byte_mask[BM_CTRL_LO]) begin
				psc_q     <= ctrl[1:0];
				cascade_q <= ctrl[CTRL_CASCADE];
				irq_en_q  <= ctrl[CTRL_IRQ_EN];
				run_q     <= ctrl[CTRL_START];
				// start edge: load counter, clear prescaler
				if (!run_q && ctrl[CTRL_START]) begin
					count_q   <= reload_nx_ext;
					residue_q <= '0;
				end
			end
			if (ctl.tick && run_q && !use_carry) begin
				residue_q <= roll ? '0 : res_inc[RES_W-1:0];
			end
			if (inc) begin
				count_q <= ovf ? reload_ext : count_q + COUNT_WIDTH'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/cptb_checker.sv
// Port-level checker for the timer bank, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module cptb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [1:0]  cmd,
	input wire logic [1:0]  timer_sel,
	input wire logic [3:0]  byte_mask,
	input wire logic [31:0] write_data,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] read_data,
	input wire logic [3:0]  irq_pulse
);
	import cptb_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	`CPTB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`CPTB_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(read_data) && $stable(irq_pulse))
	`CPTB_ASSERT_NOW(a_stall_only_full, clk, arst_n, in_stall, out_valid && out_stall)
	`CPTB_ASSERT_NEXT(a_rd_zero, clk, arst_n, in_acc && (cmd != CMD_READ), out_valid && (read_data == 16'd0))
	`CPTB_ASSERT_NEXT(a_irq_tick, clk, arst_n, in_acc && (cmd != CMD_TICK), out_valid && (irq_pulse == 4'd0))

endmodule

bind cascadable_prescaled_timer_bank_core cptb_checker u_cptb_checker (.*);
`default_nettype wire
